[hw/rtl/csu_pkg.sv]
`default_nettype none
package csu_pkg;

  localparam int ELEM_WIDTH_DEF = 16;
  localparam int ACC_W          = 48;
  localparam int HALF_W         = ACC_W / 2;
  localparam int WIDE_W         = 2 * ACC_W;
  localparam int SIM_W          = 16;
  localparam int QT_W           = 2 * (SIM_W - 1);
  localparam int CNT_W          = 5;
  localparam int PP_CNT         = 8;

  localparam logic [1:0] POS_LO  = 2'd0;
  localparam logic [1:0] POS_MID = 2'd1;
  localparam logic [1:0] POS_HI  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_BB,
    S_MUL_AB,
    S_SETTLE,
    S_CHECK,
    S_MUL_WIDE,
    S_DRAIN,
    S_CMP,
    S_DIV,
    S_SQRT,
    S_DONE
  } csu_state_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_SA,
    ACC_SB,
    ACC_DOT,
    ACC_P,
    ACC_R
  } acc_sel_t;

  typedef struct packed {
    acc_sel_t   sel;
    logic [1:0] pos;
  } mul_tag_t;

endpackage
`default_nettype wire

[hw/rtl/csu_mul.sv]
`default_nettype none
module csu_mul #(
  parameter int MUL_W = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic signed [MUL_W-1:0]      op_a,
  input  wire logic signed [MUL_W-1:0]      op_b,
  input  wire csu_pkg::mul_tag_t            tag_in,
  output logic signed [2*MUL_W-1:0]         prod_r,
  output csu_pkg::mul_tag_t                 tag_r
);
  import csu_pkg::*;

  logic signed [2*MUL_W-1:0] prod;

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '{sel: ACC_NONE, pos: POS_LO};
    end else if (en) begin
      tag_r <= tag_in;
    end else begin
      tag_r <= '{sel: ACC_NONE, pos: POS_LO};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/csu_cmpsub.sv]
`default_nettype none
module csu_cmpsub (
  input  wire logic [csu_pkg::WIDE_W-1:0] a,
  input  wire logic [csu_pkg::WIDE_W-1:0] b,
  output logic      [csu_pkg::WIDE_W-1:0] diff,
  output logic                            ge
);
  import csu_pkg::*;

  logic [WIDE_W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[WIDE_W-1:0];
  assign ge   = ~full[WIDE_W];

endmodule
`default_nettype wire

[hw/rtl/cosine_similarity_unit_core.sv]
// Streaming cosine similarity. Element pairs (signed Q4.12) enter on the in_ stream, with
// in_tlast on the final pair; one result per vector pair leaves on the out_ stream as signed
// Q1.15 in out_tdata, clamped to 32767 at the top, with out_tuser set (and a result of 0) when
// either vector is all zeros. A single multiplier forms a*a, b*b and a*b in turn, so
// in_tready is high only between pairs. The last pair then runs a closing sequence on the same
// multiplier and one shared 96-bit compare/subtract unit: settle and check, 8 partial
// products and a drain for the two 96-bit products, a compare (which ends early when the
// cosine is at least 1.0), 30 steps of restoring division and 15 steps of square root,
// then the hand-off of the result to the output register. A zero vector or a zero dot
// product skips that sequence. The output register holds one result while the next vector
// streams in. Accumulators saturate at their 48-bit signed limits.
`default_nettype none
module cosine_similarity_unit_core #(
  parameter int ELEM_WIDTH = csu_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // elem_a, elem_b
  input  wire logic [((2*ELEM_WIDTH+7)/8)*8-1:0]     in_tdata,
  input  wire logic                                  in_tlast,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // similarity
  output logic [csu_pkg::SIM_W-1:0]                  out_tdata,
  // zero_magnitude
  output logic                                       out_tuser
);
  import csu_pkg::*;

  localparam int MUL_W = (ELEM_WIDTH > HALF_W) ? ELEM_WIDTH : HALF_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_acc(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [SUM_W-1:0] sum;
    sum = SUM_W'(acc) + SUM_W'(p);
    if (sum > SUM_W'(ACC_MAX)) begin
      sat_acc = ACC_MAX;
    end else if (sum < SUM_W'(ACC_MIN)) begin
      sat_acc = ACC_MIN;
    end else begin
      sat_acc = sum[ACC_W-1:0];
    end
  endfunction

  csu_state_t state_r, state_nxt;

  logic signed [ELEM_WIDTH-1:0] in_a, in_b;
  logic signed [ELEM_WIDTH-1:0] elem_a_r, elem_a_nxt, elem_b_r, elem_b_nxt;
  logic                         last_r, last_nxt;
  logic signed [ACC_W-1:0]      sa_r, sa_nxt, sb_r, sb_nxt, dot_r, dot_nxt;
  logic [ACC_W-1:0]             d_r, d_nxt;
  logic                         neg_r, neg_nxt;
  logic [WIDE_W-1:0]            p_r, p_nxt, r_r, r_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [QT_W-1:0]              qt_r, qt_nxt;
  logic [QT_W:0]                res_r, res_nxt, one_r, one_nxt;
  logic [QT_W:0]                root_sum, res_step;
  logic [SIM_W-1:0]             res_sim_r, res_sim_nxt;
  logic                         res_zero_r, res_zero_nxt;
  logic [SIM_W-1:0]             out_data_r, out_data_nxt;
  logic                         out_zero_r, out_zero_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         in_accept;
  logic                         mul_en;
  logic signed [MUL_W-1:0]      mul_a, mul_b;
  mul_tag_t                     mul_tag, tag_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic [WIDE_W-1:0]            wide_add;
  logic [ACC_W-1:0]             mul_src_x, mul_src_y;
  logic [WIDE_W-1:0]            cmp_a, cmp_b, cmp_diff;
  logic                         cmp_ge;
  logic                         fin;
  logic [SIM_W-1:0]             q_fin;

  assign in_a      = in_tdata[ELEM_WIDTH-1:0];
  assign in_b      = in_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  csu_mul #(
    .MUL_W (MUL_W)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .tag_in (mul_tag),
    .prod_r (prod_r),
    .tag_r  (tag_r)
  );

  csu_cmpsub u_cmpsub (
    .a    (cmp_a),
    .b    (cmp_b),
    .diff (cmp_diff),
    .ge   (cmp_ge)
  );

  // partial product placed at its weight
  always_comb begin
    case (tag_r.pos)
      POS_LO:  wide_add = WIDE_W'(prod_r[ACC_W-1:0]);
      POS_MID: wide_add = WIDE_W'(prod_r[ACC_W-1:0]) << HALF_W;
      default: wide_add = WIDE_W'(prod_r[ACC_W-1:0]) << ACC_W;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    elem_a_nxt    = elem_a_r;
    elem_b_nxt    = elem_b_r;
    last_nxt      = last_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    dot_nxt       = dot_r;
    d_nxt         = d_r;
    neg_nxt       = neg_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    qt_nxt        = qt_r;
    res_nxt       = res_r;
    one_nxt       = one_r;
    res_sim_nxt   = res_sim_r;
    res_zero_nxt  = res_zero_r;
    out_data_nxt  = out_data_r;
    out_zero_nxt  = out_zero_r;
    out_valid_nxt = out_valid_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    mul_tag       = '{sel: ACC_NONE, pos: POS_LO};
    mul_src_x     = '0;
    mul_src_y     = '0;
    cmp_a         = '0;
    cmp_b         = '0;
    root_sum      = res_r + one_r;
    res_step      = res_r >> 1;
    fin           = 1'b0;
    q_fin         = '0;

    case (tag_r.sel)
      ACC_SA:  sa_nxt = sat_acc(sa_r, prod_r);
      ACC_SB:  sb_nxt = sat_acc(sb_r, prod_r);
      ACC_DOT: dot_nxt = sat_acc(dot_r, prod_r);
      ACC_P:   p_nxt = p_r + wide_add;
      ACC_R:   r_nxt = r_r + wide_add;
      default: ;
    endcase

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          elem_a_nxt = in_a;
          elem_b_nxt = in_b;
          last_nxt   = in_tlast;
          mul_en     = 1'b1;
          mul_a      = MUL_W'(in_a);
          mul_b      = MUL_W'(in_a);
          mul_tag    = '{sel: ACC_SA, pos: POS_LO};
          state_nxt  = S_MUL_BB;
        end
      end
      S_MUL_BB: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(elem_b_r);
        mul_b     = MUL_W'(elem_b_r);
        mul_tag   = '{sel: ACC_SB, pos: POS_LO};
        state_nxt = S_MUL_AB;
      end
      S_MUL_AB: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(elem_a_r);
        mul_b     = MUL_W'(elem_b_r);
        mul_tag   = '{sel: ACC_DOT, pos: POS_LO};
        state_nxt = last_r ? S_SETTLE : S_IDLE;
      end
      S_SETTLE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sa_r[ACC_W-1] || sa_r == '0 || sb_r[ACC_W-1] || sb_r == '0) begin
          res_sim_nxt  = '0;
          res_zero_nxt = 1'b1;
          state_nxt    = S_DONE;
        end else if (dot_r == '0) begin
          res_sim_nxt  = '0;
          res_zero_nxt = 1'b0;
          state_nxt    = S_DONE;
        end else begin
          neg_nxt   = dot_r[ACC_W-1];
          d_nxt     = dot_r[ACC_W-1] ? ('0 - dot_r) : dot_r;
          p_nxt     = '0;
          r_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = S_MUL_WIDE;
        end
      end
      S_MUL_WIDE: begin
        // sa*sb into p, then d*d into r, from 24-bit halves
        mul_src_x = cnt_r[2] ? d_r : sa_r;
        mul_src_y = cnt_r[2] ? d_r : sb_r;
        mul_en    = 1'b1;
        case (cnt_r[1:0])
          2'd0: begin
            mul_a   = MUL_W'({1'b0, mul_src_x[HALF_W-1:0]});
            mul_b   = MUL_W'({1'b0, mul_src_y[HALF_W-1:0]});
            mul_tag = '{sel: (cnt_r[2] ? ACC_R : ACC_P), pos: POS_LO};
          end
          2'd1: begin
            mul_a   = MUL_W'({1'b0, mul_src_x[HALF_W-1:0]});
            mul_b   = MUL_W'({1'b0, mul_src_y[ACC_W-1:HALF_W]});
            mul_tag = '{sel: (cnt_r[2] ? ACC_R : ACC_P), pos: POS_MID};
          end
          2'd2: begin
            mul_a   = MUL_W'({1'b0, mul_src_x[ACC_W-1:HALF_W]});
            mul_b   = MUL_W'({1'b0, mul_src_y[HALF_W-1:0]});
            mul_tag = '{sel: (cnt_r[2] ? ACC_R : ACC_P), pos: POS_MID};
          end
          default: begin
            mul_a   = MUL_W'({1'b0, mul_src_x[ACC_W-1:HALF_W]});
            mul_b   = MUL_W'({1'b0, mul_src_y[ACC_W-1:HALF_W]});
            mul_tag = '{sel: (cnt_r[2] ? ACC_R : ACC_P), pos: POS_HI};
          end
        endcase
        if (cnt_r == CNT_W'(PP_CNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // d^2 >= P means the cosine is at least 1.0
        cmp_a = r_r;
        cmp_b = p_r;
        if (cmp_ge) begin
          fin   = 1'b1;
          q_fin = {1'b1, {(SIM_W-1){1'b0}}};
        end else begin
          cnt_nxt   = '0;
          qt_nxt    = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // floor(d^2 * 2^30 / P), one bit per cycle
        cmp_a = {r_r[WIDE_W-2:0], 1'b0};
        cmp_b = p_r;
        if (cmp_ge) begin
          r_nxt  = cmp_diff;
          qt_nxt = {qt_r[QT_W-2:0], 1'b1};
        end else begin
          r_nxt  = cmp_a;
          qt_nxt = {qt_r[QT_W-2:0], 1'b0};
        end
        if (cnt_r == CNT_W'(QT_W - 1)) begin
          cnt_nxt   = '0;
          res_nxt   = '0;
          one_nxt   = (QT_W+1)'(1) << (QT_W - 2);
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_SQRT: begin
        cmp_a = WIDE_W'(qt_r);
        cmp_b = WIDE_W'(root_sum);
        if (cmp_ge) begin
          qt_nxt   = cmp_diff[QT_W-1:0];
          res_step = (res_r >> 1) + one_r;
        end
        res_nxt = res_step;
        one_nxt = one_r >> 2;
        if (cnt_r == CNT_W'(SIM_W - 2)) begin
          fin   = 1'b1;
          q_fin = res_step[SIM_W-1:0];
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = res_sim_r;
          out_zero_nxt  = res_zero_r;
          out_valid_nxt = 1'b1;
          sa_nxt        = '0;
          sb_nxt        = '0;
          dot_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (neg_r) begin
        res_sim_nxt = '0 - q_fin;
      end else if (q_fin[SIM_W-1]) begin
        res_sim_nxt = {1'b0, {(SIM_W-1){1'b1}}};
      end else begin
        res_sim_nxt = q_fin;
      end
      res_zero_nxt = 1'b0;
      state_nxt    = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sa_r        <= '0;
      sb_r        <= '0;
      dot_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sa_r        <= sa_nxt;
      sb_r        <= sb_nxt;
      dot_r       <= dot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_a_r   <= elem_a_nxt;
    elem_b_r   <= elem_b_nxt;
    last_r     <= last_nxt;
    d_r        <= d_nxt;
    neg_r      <= neg_nxt;
    p_r        <= p_nxt;
    r_r        <= r_nxt;
    cnt_r      <= cnt_nxt;
    qt_r       <= qt_nxt;
    res_r      <= res_nxt;
    one_r      <= one_nxt;
    res_sim_r  <= res_sim_nxt;
    res_zero_r <= res_zero_nxt;
    out_data_r <= out_data_nxt;
    out_zero_r <= out_zero_nxt;
  end

endmodule
`default_nettype wire

[bench/cosine_similarity_unit_core_tb.sv]
`default_nettype none
module cosine_similarity_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ACC_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_BOT = -ACC_TOP - 1;
  localparam int LONG_LEN = 40;
  localparam int RANDOM_ITEMS = 1150;
  localparam int ROWS = 24;

  typedef struct packed {
    logic [csu_pkg::SIM_W-1:0] sim;
    logic                      zero;
  } cos_result_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic        last;
    logic        pinned;
    logic [15:0] sim;
    logic        zero;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // elem_a, elem_b
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // similarity
  logic        out_tuser;  // zero_magnitude

  longint      dot_sum, energy_a, energy_b;
  cos_result_t pending_cos[$];
  int          mismatch_cnt;
  bit          tx_fast;
  bit          rx_hold_req;
  bit          pin_valid;
  cos_result_t pin_value;
  dir_row_t    dir_rows[ROWS];

  cosine_similarity_unit_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat48(longint acc, longint p);
    longint s;
    s = acc + p;
    if (s > ACC_TOP) return ACC_TOP;
    if (s < ACC_BOT) return ACC_BOT;
    return s;
  endfunction

  // floor(|dot| * 2^15 / sqrt(sa * sb)) by binary search on q*q*sa*sb <= dot^2 * 2^30
  function automatic cos_result_t cosine_q15(longint dot, longint sa, longint sb);
    cos_result_t r;
    logic [127:0] wa, wb, wd, mag_prod, num, q2;
    longint lo, hi, mid;
    r = '0;
    if (sa <= 0 || sb <= 0) begin
      r.zero = 1'b1;
    end else if (dot != 0) begin
      wa = sa;
      wb = sb;
      wd = (dot < 0) ? -dot : dot;
      mag_prod = wa * wb;
      num = (wd * wd) << 30;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        q2 = mid * mid;
        if (q2 * mag_prod <= num) lo = mid;
        else hi = mid - 1;
      end
      if (dot < 0) r.sim = 16'(-lo);
      else r.sim = (lo > 32767) ? 16'd32767 : 16'(lo);
    end
    return r;
  endfunction

  task automatic absorb_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic last, output bit emits, output cos_result_t res);
    longint p_ab, p_aa, p_bb;
    p_ab = a * b;
    p_aa = a * a;
    p_bb = b * b;
    dot_sum = sat48(dot_sum, p_ab);
    energy_a = sat48(energy_a, p_aa);
    energy_b = sat48(energy_b, p_bb);
    emits = last;
    res = '0;
    if (last) begin
      res = cosine_q15(dot_sum, energy_a, energy_b);
      dot_sum = 0;
      energy_a = 0;
      energy_b = 0;
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : take_item
    bit emits;
    cos_result_t res;
    if (rst_n && in_tvalid && in_tready) begin
      absorb_pair(in_tdata[15:0], in_tdata[31:16], in_tlast, emits, res);
      if (emits) pending_cos.push_back(pin_valid ? pin_value : res);
    end
  end

  always @(posedge clk) begin : check_result
    cos_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cos.size() == 0) begin
        note_mismatch($sformatf("unexpected result sim=%0d zero=%0b",
                                $signed(out_tdata), out_tuser));
      end else begin
        want = pending_cos.pop_front();
        if (out_tdata !== want.sim)
          note_mismatch($sformatf("similarity exp %0d got %0d",
                                  $signed(want.sim), $signed(out_tdata)));
        if (out_tuser !== want.zero)
          note_mismatch($sformatf("zero_magnitude exp %0b got %0b", want.zero, out_tuser));
      end
    end
  end

  // receiver: a random stall before each item, bursts without stalls, one long hold on request
  initial begin : rx
    int gap, burst_left;
    out_tready = 1'b0;
    burst_left = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else begin
          gap = $urandom_range(0, 7);
          if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 24);
        end
        if (gap > 0) begin
          out_tready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last,
                           input bit pinned, input cos_result_t pin_res);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {b, a};
    in_tlast = last;
    pin_valid = pinned;
    pin_value = pin_res;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_results;
    in_tvalid = 1'b0;
    while (pending_cos.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3, 4: return 16'($urandom_range(0, 128)) - 16'd64;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_vector(output int len);
    int kind, shift;
    logic signed [15:0] a, b;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 6);
    kind = $urandom_range(0, 6);
    shift = $urandom_range(0, 3);
    tx_fast = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      a = rand_elem();
      b = rand_elem();
      case (kind)
        1: b = a;
        2: b = -a;
        3: b = a >>> shift;
        4: a = '0;
        5: b = '0;
        default: ;
      endcase
      send_pair(a, b, i == len - 1, 1'b0, '0);
    end
  endtask

  // long vectors of extreme elements, back to back
  task automatic send_long_vector(input logic [15:0] a, input logic [15:0] b);
    tx_fast = 1'b1;
    for (int i = 0; i < LONG_LEN; i++) send_pair(a, b, i == LONG_LEN - 1, 1'b0, '0);
    tx_fast = 1'b0;
  endtask

  initial begin : stim
    int sent, len;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    pin_valid = 1'b0;
    pin_value = '0;
    tx_fast = 1'b0;
    rx_hold_req = 1'b0;
    mismatch_cnt = 0;
    dot_sum = 0;
    energy_a = 0;
    energy_b = 0;
    // a, b, last, pinned, similarity, zero_magnitude
    dir_rows = '{
      '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1},
      '{16'h1000, 16'h1000, 1'b1, 1'b1, 16'h7FFF, 1'b0},
      '{16'h1000, 16'hF000, 1'b1, 1'b1, 16'h8000, 1'b0},
      '{16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b0},
      '{16'h8000, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 1'b0},
      '{16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'h8000, 1'b0},
      '{16'h0005, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1},
      '{16'h0000, 16'hFFFB, 1'b1, 1'b1, 16'h0000, 1'b1},
      '{16'h0001, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 16'h0001, 1'b1, 1'b1, 16'h0000, 1'b0},
      '{16'h0003, 16'h0004, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0004, 16'hFFFD, 1'b1, 1'b1, 16'h0000, 1'b0},
      '{16'h1000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 16'h1000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h1000, 16'h1000, 1'b1, 1'b1, 16'h4000, 1'b0},
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1},
      '{16'h8000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 16'h8000, 1'b1, 1'b1, 16'h0000, 1'b0},
      '{16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h1234, 16'hEDCB, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0001, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'h5555, 16'hAAAA, 1'b1, 1'b0, 16'h0000, 1'b0}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last, dir_rows[i].pinned,
                '{sim: dir_rows[i].sim, zero: dir_rows[i].zero});
    wait_results();

    // receiver holds off while single-pair vectors pile up behind it
    rx_hold_req = 1'b1;
    tx_fast = 1'b1;
    repeat (12) send_pair(rand_elem(), rand_elem(), 1'b1, 1'b0, '0);
    tx_fast = 1'b0;
    wait_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      send_random_vector(len);
      sent += len;
    end
    wait_results();

    send_long_vector(16'h8000, 16'h8000);
    send_long_vector(16'h8000, 16'h7FFF);

    in_tvalid = 1'b0;
    for (int k = 0; k < 20000 && pending_cos.size() != 0; k++) @(posedge clk);
    repeat (200) @(posedge clk);
    if (pending_cos.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_cos.size()));
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

[cosine_similarity_unit_core.f]
hw/rtl/csu_pkg.sv
hw/rtl/csu_mul.sv
hw/rtl/csu_cmpsub.sv
hw/rtl/cosine_similarity_unit_core.sv
bench/cosine_similarity_unit_core_tb.sv
